// ===== hw/rtl/priority_truncated_force_sum_assert.svh =====
// Assertion macros for the prioritised truncated force sum checks.
`ifndef PRIORITY_TRUNCATED_FORCE_SUM_ASSERT_SVH
`define PRIORITY_TRUNCATED_FORCE_SUM_ASSERT_SVH

// Clocked assertion with asynchronous reset disable.
`define PTFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on the following clock edge.
`define PTFS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/ptfs_pkg.sv =====
// ----------------------------------------------------------------------------
// ptfs_pkg
// Shared widths and helper functions for the prioritised truncated force sum.
// ----------------------------------------------------------------------------
package ptfs_pkg;

	localparam int FW   = 20;
	localparam int WW   = 16;
	localparam int MW   = 24;
	localparam int RW   = 25;
	localparam int SQW  = 2 * RW;
	localparam int DVW  = 45;
	localparam int CNTW = 5;

	localparam logic [FW-1:0] MAX_FORCE_RST = 20'd102400;

	function automatic logic [FW-1:0] abs_f(input logic signed [FW-1:0] v);
		abs_f = v[FW-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic signed [FW-1:0] sat_add(input logic signed [FW-1:0] t,
		input logic [RW-1:0] mag, input logic neg);
		logic [26:0] m;
		logic [26:0] s;
		m = {2'b00, mag};
		s = {{7{t[FW-1]}}, t} + (neg ? (~m + 1'b1) : m);
		if ($signed(s) > 27'sd524287) begin
			sat_add = 20'sd524287;
		end else if ($signed(s) < -27'sd524288) begin
			sat_add = -20'sd524288;
		end else begin
			sat_add = s[FW-1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/ptfs_sqrt.sv =====
// ----------------------------------------------------------------------------
// ptfs_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ptfs_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ptfs_pkg::SQW-1:0]   radicand,
	output logic                       done,
	output logic [ptfs_pkg::RW-1:0]    root
);
	import ptfs_pkg::*;

	logic [SQW-1:0]  rad_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW+2:0]   r2;
	logic [RW+2:0]   trial;
	logic            ge;

	assign r2    = {rem_q, rad_q[SQW-1:SQW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (r2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQW-3:0], 2'b00};
			rem_q  <= ge ? (RW+1)'(r2 - trial) : r2[RW:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hw/rtl/ptfs_div.sv =====
// ----------------------------------------------------------------------------
// ptfs_div
// Restoring divider, one quotient bit per cycle, quotient below 2^25.
// ----------------------------------------------------------------------------
module ptfs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ptfs_pkg::DVW-1:0]   dividend,
	input  logic [ptfs_pkg::RW-1:0]    divisor,
	output logic                       done,
	output logic [ptfs_pkg::RW-1:0]    quotient
);
	import ptfs_pkg::*;

	logic [RW-1:0]   rem_q;
	logic [RW-1:0]   dvd_q;
	logic [RW-1:0]   dsr_q;
	logic [RW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW:0]     t;
	logic            ge;

	assign t  = {rem_q, dvd_q[RW-1]};
	assign ge = (t >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(2 * RW - DVW){1'b0}}, dividend[DVW-1:RW]};
			dvd_q <= dividend[RW-1:0];
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? RW'(t - {1'b0, dsr_q}) : t[RW-1:0];
			dvd_q <= {dvd_q[RW-2:0], 1'b0};
			quo_q <= {quo_q[RW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/priority_truncated_force_sum.sv =====
// Paths: an item of a finished frame ends at the done check, one with no budget left after
// the square root of the total, one whose force fits the budget after a second square root
// and the add, and a scaled one after that and three divisions. Throughput: one word at a
// time; the next word is taken only once the result is registered, so items never overlap.
// Reset: asynchronous, active low; clears the total, the done mark and sets
// max_force to 400.0.
// ----------------------------------------------------------------------------
// priority_truncated_force_sum
// Prioritised truncated sum of weighted steering forces, sequenced over a
// shared multiplier, square root unit and divider.
// ----------------------------------------------------------------------------
module priority_truncated_force_sum (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            frame_start,
	input  logic signed [ptfs_pkg::FW-1:0]  force_x,
	input  logic signed [ptfs_pkg::FW-1:0]  force_y,
	input  logic signed [ptfs_pkg::FW-1:0]  force_z,
	input  logic [ptfs_pkg::WW-1:0]         weight,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [ptfs_pkg::FW-1:0]  total_x,
	output logic signed [ptfs_pkg::FW-1:0]  total_y,
	output logic signed [ptfs_pkg::FW-1:0]  total_z,
	output logic                            keep_going,
	input  logic                            cfg_we,
	input  logic [ptfs_pkg::FW-1:0]         cfg_data
);
	import ptfs_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_CHK   = 13'b0000000000010,
		ST_TSQ   = 13'b0000000000100,
		ST_TGO   = 13'b0000000001000,
		ST_TWAIT = 13'b0000000010000,
		ST_WC    = 13'b0000000100000,
		ST_WSQ   = 13'b0000001000000,
		ST_WGO   = 13'b0000010000000,
		ST_WWAIT = 13'b0000100000000,
		ST_ADD   = 13'b0001000000000,
		ST_SCL   = 13'b0010000000000,
		ST_DGO   = 13'b0100000000000,
		ST_DWAIT = 13'b1000000000000
	} state_t;

	state_t                state_q;
	logic                  fin_q;
	logic [FW-1:0]         max_force_q;
	logic signed [FW-1:0]  tot_q [3];
	logic                  done_q;
	logic                  keep_q;
	logic signed [FW-1:0]  f_q [3];
	logic [WW-1:0]         w_q;
	logic [1:0]            idx_q;
	logic [MW-1:0]         m_q [3];
	logic [SQW-1:0]        acc_q;
	logic [FW-1:0]         left_q;
	logic [RW-1:0]         len_q;
	logic [43:0]           prod_q;
	logic                  ov_q;
	logic signed [FW-1:0]  ox_q;
	logic signed [FW-1:0]  oy_q;
	logic signed [FW-1:0]  oz_q;
	logic                  ok_q;

	logic [RW-1:0]  mul_a;
	logic [RW-1:0]  mul_b;
	logic [SQW-1:0] mul_p;
	logic [35:0]    wsum;
	logic           sq_start;
	logic           sq_done;
	logic [RW-1:0]  sq_root;
	logic           dv_start;
	logic           dv_done;
	logic [RW-1:0]  dv_quo;
	logic [DVW-1:0] dv_dividend;
	logic [25:0]    lft;
	logic           out_free;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_TSQ: begin
				mul_a = RW'(abs_f(tot_q[idx_q]));
				mul_b = RW'(abs_f(tot_q[idx_q]));
			end
			ST_WC: begin
				mul_a = RW'(abs_f(f_q[idx_q]));
				mul_b = RW'(w_q);
			end
			ST_WSQ: begin
				mul_a = RW'(m_q[idx_q]);
				mul_b = RW'(m_q[idx_q]);
			end
			ST_SCL: begin
				mul_a = RW'(m_q[idx_q]);
				mul_b = RW'(left_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p       = mul_a * mul_b;
	assign wsum        = mul_p[35:0] + 36'd2048;
	assign sq_start    = (state_q == ST_TGO) || (state_q == ST_WGO);
	assign dv_start    = (state_q == ST_DGO);
	assign dv_dividend = {1'b0, prod_q} + DVW'(len_q[RW-1:1]);
	assign lft         = {6'b0, max_force_q} - {1'b0, sq_root};
	assign out_free    = !ov_q || out_ready;

	ptfs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (acc_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	ptfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_dividend),
		.divisor  (len_q),
		.done     (dv_done),
		.quotient (dv_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_force_q <= MAX_FORCE_RST;
		end else if (cfg_we) begin
			max_force_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q   <= 1'b0;
			idx_q   <= '0;
			done_q  <= 1'b0;
			keep_q  <= 1'b0;
			ov_q    <= 1'b0;
			tot_q[0] <= '0;
			tot_q[1] <= '0;
			tot_q[2] <= '0;
		end else begin
			if (fin_q && out_free) begin
				fin_q  <= 1'b0;
				ov_q   <= 1'b1;
				done_q <= done_q || !keep_q;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !fin_q) begin
						keep_q <= 1'b0;
						if (frame_start) begin
							tot_q[0] <= '0;
							tot_q[1] <= '0;
							tot_q[2] <= '0;
							done_q   <= 1'b0;
						end
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					idx_q <= '0;
					if (done_q) begin
						fin_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_TSQ;
					end
				end
				ST_TSQ: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == 2'd2) begin
						state_q <= ST_TGO;
					end
				end
				ST_TGO: begin
					state_q <= ST_TWAIT;
				end
				ST_TWAIT: begin
					if (sq_done) begin
						idx_q <= '0;
						if (!lft[25] && (lft != '0)) begin
							state_q <= ST_WC;
						end else begin
							fin_q   <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_WC: begin
					idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 1'b1;
					if (idx_q == 2'd2) begin
						state_q <= ST_WSQ;
					end
				end
				ST_WSQ: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == 2'd2) begin
						state_q <= ST_WGO;
					end
				end
				ST_WGO: begin
					state_q <= ST_WWAIT;
				end
				ST_WWAIT: begin
					if (sq_done) begin
						idx_q <= '0;
						if ({5'b0, left_q} > sq_root) begin
							state_q <= ST_ADD;
						end else begin
							state_q <= ST_SCL;
						end
					end
				end
				ST_ADD: begin
					tot_q[0] <= sat_add(tot_q[0], RW'(m_q[0]), f_q[0][FW-1]);
					tot_q[1] <= sat_add(tot_q[1], RW'(m_q[1]), f_q[1][FW-1]);
					tot_q[2] <= sat_add(tot_q[2], RW'(m_q[2]), f_q[2][FW-1]);
					keep_q   <= 1'b1;
					fin_q    <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_SCL: begin
					state_q <= ST_DGO;
				end
				ST_DGO: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (dv_done) begin
						tot_q[idx_q] <= sat_add(tot_q[idx_q], dv_quo, f_q[idx_q][FW-1]);
						idx_q <= idx_q + 1'b1;
						if (idx_q == 2'd2) begin
							fin_q   <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SCL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			f_q[0] <= force_x;
			f_q[1] <= force_y;
			f_q[2] <= force_z;
			w_q    <= weight;
		end
		if (state_q == ST_TSQ || state_q == ST_WSQ) begin
			acc_q <= (idx_q == 2'd0) ? mul_p : acc_q + mul_p;
		end
		if (state_q == ST_WC) begin
			m_q[idx_q] <= wsum[35:12];
		end
		if (state_q == ST_TWAIT && sq_done) begin
			left_q <= lft[FW-1:0];
		end
		if (state_q == ST_WWAIT && sq_done) begin
			len_q <= sq_root;
		end
		if (state_q == ST_SCL) begin
			prod_q <= mul_p[43:0];
		end
		if (fin_q && out_free) begin
			ox_q <= tot_q[0];
			oy_q <= tot_q[1];
			oz_q <= tot_q[2];
			ok_q <= keep_q;
		end
	end

	assign in_ready   = (state_q == ST_IDLE) && !fin_q;
	assign out_valid  = ov_q;
	assign total_x    = ox_q;
	assign total_y    = oy_q;
	assign total_z    = oz_q;
	assign keep_going = ok_q;

endmodule

// ===== hw/rtl/ptfs_checker.sv =====
// ----------------------------------------------------------------------------
// ptfs_checker
// Port-level checks on the prioritised truncated force sum, bound to the top.
// ----------------------------------------------------------------------------
`include "priority_truncated_force_sum_assert.svh"

module ptfs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic signed [ptfs_pkg::FW-1:0]  total_x,
	input logic                            keep_going
);
	import ptfs_pkg::*;

	`PTFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")
	`PTFS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(total_x) && $stable(keep_going), "result word changed while stalled")
	`PTFS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second word taken while busy")
	`PTFS_ASSERT(a_out_known, out_valid |-> !$isunknown({total_x, keep_going}), "result word unknown")

endmodule

bind priority_truncated_force_sum ptfs_checker u_ptfs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.total_x    (total_x),
	.keep_going (keep_going)
);

// ===== bench/priority_truncated_force_sum_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prioritised truncated force sum testbench
// Drives force words over a valid/ready channel with bursty gaps, stalls the
// result channel on its own pattern, and checks every result word against an
// in-bench fixed-point model of the truncated sum or a directed table, across several budgets.
// ----------------------------------------------------------------------------
module priority_truncated_force_sum_test;

	import ptfs_pkg::*;

	typedef struct packed {
		logic                  fs;
		logic signed [FW-1:0]  fx;
		logic signed [FW-1:0]  fy;
		logic signed [FW-1:0]  fz;
		logic [WW-1:0]         w;
	} force_word_t;

	typedef struct packed {
		logic signed [FW-1:0]  tx;
		logic signed [FW-1:0]  ty;
		logic signed [FW-1:0]  tz;
		logic                  kg;
	} total_word_t;

	typedef struct packed {
		force_word_t  stim;
		logic         known;
		total_word_t  res;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic frame_start;
	logic signed [FW-1:0] force_x, force_y, force_z;
	logic [WW-1:0] weight;
	logic out_valid;
	logic out_ready;
	logic signed [FW-1:0] total_x, total_y, total_z;
	logic keep_going;
	logic cfg_we;
	logic [FW-1:0] cfg_data;

	total_word_t expected_totals[$];
	int errors = 0;
	logic signed [63:0] sum_state[3];
	logic done_state;
	logic [FW-1:0] budget_reg;

	priority_truncated_force_sum DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.frame_start(frame_start), .force_x(force_x), .force_y(force_y),
		.force_z(force_z), .weight(weight),
		.out_valid(out_valid), .out_ready(out_ready),
		.total_x(total_x), .total_y(total_y), .total_z(total_z),
		.keep_going(keep_going),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] clamp_comp(input logic signed [63:0] v);
		if (v > 64'sd524287) return 64'sd524287;
		if (v < -64'sd524288) return -64'sd524288;
		return v;
	endfunction

	function automatic total_word_t predict_total(input force_word_t f);
		total_word_t r;
		logic [63:0] sq, wsq, len, m, mag;
		logic signed [63:0] left, comp;
		logic signed [63:0] wc[3];
		logic signed [FW-1:0] fc[3];
		logic keep;
		keep = 1'b0;
		fc[0] = f.fx;
		fc[1] = f.fy;
		fc[2] = f.fz;
		if (f.fs) begin
			for (int i = 0; i < 3; i++) sum_state[i] = 0;
			done_state = 1'b0;
		end
		if (!done_state) begin
			sq = 0;
			for (int i = 0; i < 3; i++) begin
				mag = sum_state[i] < 0 ? -sum_state[i] : sum_state[i];
				sq += mag * mag;
			end
			left = $signed({44'd0, budget_reg}) - $signed(int_sqrt(sq));
			if (left > 0) begin
				wsq = 0;
				for (int i = 0; i < 3; i++) begin
					comp = fc[i];
					mag = comp < 0 ? -comp : comp;
					m = (mag * f.w + 64'd2048) >> 12;
					wc[i] = comp < 0 ? -$signed(m) : $signed(m);
					wsq += m * m;
				end
				len = int_sqrt(wsq);
				if ($signed(len) < left) begin
					for (int i = 0; i < 3; i++)
						sum_state[i] = clamp_comp(sum_state[i] + wc[i]);
					keep = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						mag = wc[i] < 0 ? -wc[i] : wc[i];
						m = (mag * left + len / 2) / len;
						comp = wc[i] < 0 ? -$signed(m) : $signed(m);
						sum_state[i] = clamp_comp(sum_state[i] + comp);
					end
				end
			end
			if (!keep) done_state = 1'b1;
		end
		r.tx = sum_state[0][FW-1:0];
		r.ty = sum_state[1][FW-1:0];
		r.tz = sum_state[2][FW-1:0];
		r.kg = keep;
		return r;
	endfunction

	task automatic send_word(input force_word_t f);
		in_valid <= 1'b1;
		frame_start <= f.fs;
		force_x <= f.fx;
		force_y <= f.fy;
		force_z <= f.fz;
		weight <= f.w;
		do @(posedge clk); while (!in_ready);
		expected_totals.insert(expected_totals.size(), predict_total(f));
	endtask

	task automatic drain_results();
		while (expected_totals.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_budget(input logic [FW-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		budget_reg = v;
	endtask

	function automatic logic signed [FW-1:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return -20'sd524288;
			1: return 20'sd524287;
			2: return $signed(20'($urandom_range(0, 2047))) - 20'sd1024;
			default: return $signed(20'($urandom));
		endcase
	endfunction

	task automatic random_frames(input int n_words);
		force_word_t f;
		int sent;
		int burst;
		sent = 0;
		while (sent < n_words) begin
			burst = $urandom_range(1, 8);
			for (int k = 0; k < burst && sent < n_words; k++) begin
				f.fs = (sent == 0) || ($urandom_range(0, 4) == 0);
				f.fx = rand_comp();
				f.fy = rand_comp();
				f.fz = rand_comp();
				f.w = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8192));
				send_word(f);
				sent++;
			end
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	table_row_t directed_rows[14] = '{
		'{'{1'b1, 20'sd0, 20'sd0, 20'sd0, 16'd0}, 1'b1, '{20'sd0, 20'sd0, 20'sd0, 1'b1}},
		'{'{1'b1, 20'sd256, 20'sd0, 20'sd0, 16'd4096}, 1'b1,
			'{20'sd256, 20'sd0, 20'sd0, 1'b1}},
		'{'{1'b0, -20'sd512, 20'sd256, 20'sd0, 16'd4096}, 1'b0, '0},
		'{'{1'b1, 20'sd524287, 20'sd524287, 20'sd524287, 16'hFFFF}, 1'b0, '0},
		'{'{1'b0, 20'sd256, 20'sd256, 20'sd256, 16'd4096}, 1'b0, '0},
		'{'{1'b1, -20'sd524288, -20'sd524288, -20'sd524288, 16'hFFFF}, 1'b0, '0},
		'{'{1'b1, 20'sd102400, 20'sd0, 20'sd0, 16'd4096}, 1'b1,
			'{20'sd102400, 20'sd0, 20'sd0, 1'b0}},
		'{'{1'b0, 20'sd1, 20'sd1, 20'sd1, 16'd4096}, 1'b1,
			'{20'sd102400, 20'sd0, 20'sd0, 1'b0}},
		'{'{1'b1, 20'sd25600, 20'sd0, 20'sd0, 16'd8192}, 1'b0, '0},
		'{'{1'b0, 20'sd0, -20'sd51200, 20'sd0, 16'd4096}, 1'b0, '0},
		'{'{1'b0, 20'sd0, 20'sd0, 20'sd100000, 16'd4096}, 1'b0, '0},
		'{'{1'b0, 20'sd5, 20'sd5, 20'sd5, 16'd1}, 1'b0, '0},
		'{'{1'b1, 20'sd1000, -20'sd2000, 20'sd3000, 16'd2048}, 1'b0, '0},
		'{'{1'b0, 20'sd1000, -20'sd2000, 20'sd3000, 16'd6144}, 1'b0, '0}
	};

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		frame_start = 1'b0;
		force_x = '0;
		force_y = '0;
		force_z = '0;
		weight = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		for (int i = 0; i < 3; i++) sum_state[i] = 0;
		done_state = 1'b0;
		budget_reg = MAX_FORCE_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].stim);
			if (directed_rows[i].known) begin
				expected_totals[expected_totals.size() - 1] = directed_rows[i].res;
			end
		end
		random_frames(200);
		set_budget(20'd0);
		random_frames(40);
		set_budget(20'hFFFFF);
		random_frames(120);
		set_budget(20'd1);
		random_frames(40);
		set_budget(20'($urandom_range(256, 40000)));
		random_frames(150);
		set_budget(20'($urandom));
		random_frames(150);
		drain_results();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 30) == 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(50, 400)) @(posedge clk);
			end else begin
				case ($urandom_range(0, 3))
					0: out_ready <= 1'b0;
					default: out_ready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		total_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_totals.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				e = expected_totals.pop_front();
				if (total_x !== e.tx) begin
					$error("total_x expected %0d actual %0d", e.tx, total_x);
					errors++;
				end
				if (total_y !== e.ty) begin
					$error("total_y expected %0d actual %0d", e.ty, total_y);
					errors++;
				end
				if (total_z !== e.tz) begin
					$error("total_z expected %0d actual %0d", e.tz, total_z);
					errors++;
				end
				if (keep_going !== e.kg) begin
					$error("keep_going expected %0d actual %0d", e.kg, keep_going);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule
